FILE: src/gpv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpv_pkg
// Shared types, constants and the GF(2^8) multiply for the possession-proof
// verifier.
// ----------------------------------------------------------------------------
package gpv_pkg;

  // Number of key slots on the ports and in the register file.
  localparam int unsigned Slots = 3;

  // Low byte of the AES reduction polynomial 0x11B.
  localparam logic [7:0] GfPolyLow = 8'h1B;

  // Reset values of the key registers.
  localparam logic [Slots-1:0][7:0] KeyReset = {8'd15, 8'd200, 8'd123};

  // Register indexes on the configuration port.
  localparam logic [1:0] RegKey0 = 2'd0;
  localparam logic [1:0] RegKey1 = 2'd1;
  localparam logic [1:0] RegKey2 = 2'd2;

  typedef enum logic [1:0] {
    CmdClear = 2'd0,
    CmdTag   = 2'd1,
    CmdData  = 2'd2
  } cmd_e;

  typedef logic [Slots-1:0][7:0] byte_vec_t;

  // One input word.
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       last_byte;
    byte_vec_t  tag_byte;
    logic [7:0] coefficient;
  } item_t;

  // One result word.
  typedef struct packed {
    byte_vec_t mac;
    logic      chunk_match;
    logic      all_match;
  } res_t;

  // Carry-less multiply with reduction, one shift-and-add step per bit.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] r;
    x = a;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        r = r ^ x;
      end
      x = {x[6:0], 1'b0} ^ (x[7] ? GfPolyLow : 8'h00);
    end
    return r;
  endfunction

endpackage

FILE: src/gpv_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpv_cfg_regs
// APB-style register file holding the three secret evaluation keys.
// ----------------------------------------------------------------------------
module gpv_cfg_regs
  import gpv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output byte_vec_t   keys_o
);

  byte_vec_t  key_q;
  byte_vec_t  key_d;
  logic [1:0] reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign keys_o  = key_q;

  always_comb begin
    key_d = key_q;
    if (psel && penable && pwrite) begin
      case (reg_idx)
        RegKey0: key_d[0] = pwdata[7:0];
        RegKey1: key_d[1] = pwdata[7:0];
        RegKey2: key_d[2] = pwdata[7:0];
        default: key_d = key_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegKey0: prdata = {24'h000000, key_q[0]};
      RegKey1: prdata = {24'h000000, key_q[1]};
      RegKey2: prdata = {24'h000000, key_q[2]};
      default: prdata = 32'h00000000;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= KeyReset;
    end else begin
      key_q <= key_d;
    end
  end

endmodule

FILE: src/gpv_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpv_core
// Challenge state (tag sums, MAC sums, key powers, sticky flag) and the
// combinational update and result logic for one word.
// ----------------------------------------------------------------------------
module gpv_core
  import gpv_pkg::*;
#(
  parameter int unsigned NumKeys = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  item_t     item_i,
  input  byte_vec_t keys_i,
  output logic      res_valid_o,
  output res_t      res_o
);

  logic [NumKeys-1:0][7:0] tag_q, tag_d;
  logic [NumKeys-1:0][7:0] mac_q, mac_d;
  logic [NumKeys-1:0][7:0] pow_q, pow_d;
  logic [NumKeys-1:0][7:0] mac_new;
  logic                    sticky_q, sticky_d;
  logic                    match;
  byte_vec_t               mac_ext;

  // Running MAC including the current byte, and the chunk comparison.
  always_comb begin
    match = 1'b1;
    for (int k = 0; k < NumKeys; k++) begin
      mac_new[k] = mac_q[k] ^ gf_mul(item_i.data_byte, pow_q[k]);
      if (mac_new[k] != tag_q[k]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    tag_d    = tag_q;
    mac_d    = mac_q;
    pow_d    = pow_q;
    sticky_d = sticky_q;
    case (item_i.cmd)
      CmdClear: begin
        for (int k = 0; k < NumKeys; k++) begin
          tag_d[k] = '0;
          mac_d[k] = '0;
          pow_d[k] = keys_i[k];
        end
        sticky_d = 1'b1;
      end
      CmdTag: begin
        for (int k = 0; k < NumKeys; k++) begin
          tag_d[k] = tag_q[k] ^ gf_mul(item_i.tag_byte[k], item_i.coefficient);
        end
      end
      CmdData: begin
        for (int k = 0; k < NumKeys; k++) begin
          if (item_i.last_byte) begin
            mac_d[k] = '0;
            pow_d[k] = keys_i[k];
          end else begin
            mac_d[k] = mac_new[k];
            pow_d[k] = gf_mul(pow_q[k], keys_i[k]);
          end
        end
        if (item_i.last_byte) begin
          sticky_d = sticky_q & match;
        end
      end
      default: begin
        sticky_d = sticky_q;
      end
    endcase
  end

  for (genvar k = 0; k < Slots; k++) begin : g_mac
    if (k < NumKeys) begin : g_on
      assign mac_ext[k] = mac_new[k];
    end else begin : g_off
      assign mac_ext[k] = 8'h00;
    end
  end

  assign res_valid_o       = (item_i.cmd == CmdData) && item_i.last_byte;
  assign res_o.mac         = mac_ext;
  assign res_o.chunk_match = match;
  assign res_o.all_match   = sticky_q & match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumKeys; k++) begin
        tag_q[k] <= '0;
        mac_q[k] <= '0;
        pow_q[k] <= KeyReset[k];
      end
      sticky_q <= 1'b1;
    end else if (step_i) begin
      tag_q    <= tag_d;
      mac_q    <= mac_d;
      pow_q    <= pow_d;
      sticky_q <= sticky_d;
    end
  end

endmodule

FILE: src/gf256_proof_of_possession_verifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf256_proof_of_possession_verifier
// Possession-proof checker: GF(2^8) tag sums against keyed polynomial MACs.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on the in_valid_i / in_ready_o channel. A clear word
//   starts a new challenge, tag words fold coefficient-weighted tag bytes into
//   the tag sums, and data words stream the proof bytes of one chunk. The
//   data word marked last_byte_i produces one result word on the
//   out_valid_o / out_ready_i channel: the three MACs, chunk_match_o and the
//   sticky all_match_o. All other words produce no result.
//   Throughput is one word per cycle while the receiver does not stall. A
//   word is captured into the input register when it is accepted, and its
//   result is then written from there into the output register, where the
//   receiver takes it. Each data step is one pair of GF(2^8) multiplies per
//   key, done combinationally between the two registers.
//   If the receiver stalls, the output register holds its word; the input
//   register still takes one more word and then in_ready_o drops until the
//   result is taken. Words that produce no result also wait behind a stalled
//   result, so ordering of state updates is preserved.
//   Reset empties both registers, restores the keys to 123, 200 and 15,
//   clears tag and MAC sums, loads the key powers and sets the sticky flag.
//   The user writes the keys over the APB port only while the block is idle;
//   the block does not enforce it. Register i sits at byte address 4*i.
// ----------------------------------------------------------------------------
module gf256_proof_of_possession_verifier
  import gpv_pkg::*;
#(
  parameter int unsigned NumKeys = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [7:0]  tag_byte_0_i,
  input  logic [7:0]  tag_byte_1_i,
  input  logic [7:0]  tag_byte_2_i,
  input  logic [7:0]  coefficient_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  mac_0_o,
  output logic [7:0]  mac_1_o,
  output logic [7:0]  mac_2_o,
  output logic        chunk_match_o,
  output logic        all_match_o
);

  byte_vec_t keys;
  item_t     in_item;
  item_t     in_q;
  logic      in_valid_q;
  logic      advance;
  logic      step;
  logic      res_valid;
  res_t      res;
  res_t      out_q;
  logic      out_valid_q, out_valid_d;

  gpv_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .keys_o  (keys)
  );

  assign in_item.cmd         = cmd_i;
  assign in_item.data_byte   = data_byte_i;
  assign in_item.last_byte   = last_byte_i;
  assign in_item.tag_byte    = {tag_byte_2_i, tag_byte_1_i, tag_byte_0_i};
  assign in_item.coefficient = coefficient_i;

  // The held word moves on whenever the output register is free or drains.
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item;
    end
  end

  gpv_core #(
    .NumKeys (NumKeys)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_q),
    .keys_i      (keys),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = step && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign mac_0_o       = out_q.mac[0];
  assign mac_1_o       = out_q.mac[1];
  assign mac_2_o       = out_q.mac[2];
  assign chunk_match_o = out_q.chunk_match;
  assign all_match_o   = out_q.all_match;

  // An empty result register never blocks the input side.
  a_ready_when_empty : assert property (
    @(posedge clk_i) disable iff (!rst_ni) !out_valid_q |-> in_ready_o
  ) else $error("input stalled while the result register is empty");

  // A fresh result only follows a last data word in the input register.
  a_result_source : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |->
      $past(in_valid_q && (in_q.cmd == CmdData) && in_q.last_byte)
  ) else $error("result appeared without a last data word");

  // The sticky flag includes the current chunk.
  a_all_implies_chunk : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && all_match_o) |-> chunk_match_o
  ) else $error("all_match set on a mismatching chunk");

endmodule

FILE: sim/gf256_proof_of_possession_verifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf256_proof_of_possession_verifier_tb
// Self-checking bench for the GF(2^8) possession-proof verifier. It runs a
// short directed sequence and then random challenges, predicts every result
// word and compares it field by field.
// ----------------------------------------------------------------------------
module gf256_proof_of_possession_verifier_tb;
  import gpv_pkg::*;

  localparam int unsigned KeyCount = Slots;
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam logic [1:0] RegUnused = 2'd3;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned DrainCycles = 6;

  // Tracks the verifier state, predicts verdict words and checks them.
  class pop_tracker;
    int unsigned live_keys;
    int unsigned mismatches;
    int unsigned verdicts_seen;
    byte_vec_t   key_reg;
    byte_vec_t   tag_acc;
    byte_vec_t   mac_run;
    byte_vec_t   pow_run;
    logic        all_ok;
    res_t        verdicts_due[$];

    function new(int unsigned n);
      live_keys = n;
      mismatches = 0;
      verdicts_seen = 0;
      key_reg = KeyReset;
      tag_acc = '0;
      all_ok = 1'b1;
      restart_chunk();
    endfunction

    // Horner form, most significant bit of a first.
    static function logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      acc = '0;
      for (int i = 7; i >= 0; i--) begin
        acc = {acc[6:0], 1'b0} ^ (acc[7] ? GfPolyLow : 8'h00);
        if (a[i]) begin
          acc = acc ^ b;
        end
      end
      return acc;
    endfunction

    function void restart_chunk();
      mac_run = '0;
      for (int k = 0; k < Slots; k++) begin
        pow_run[k] = (k < live_keys) ? key_reg[k] : 8'h00;
      end
    endfunction

    function void set_key(logic [1:0] idx, logic [7:0] value);
      if (idx < Slots) begin
        key_reg[idx] = value;
      end
    endfunction

    function void absorb_word(item_t w);
      res_t v;
      logic ok;
      case (w.cmd)
        CmdClear: begin
          tag_acc = '0;
          restart_chunk();
          all_ok = 1'b1;
        end
        CmdTag: begin
          for (int k = 0; k < live_keys; k++) begin
            tag_acc[k] = tag_acc[k] ^ gf_times(w.tag_byte[k], w.coefficient);
          end
        end
        CmdData: begin
          for (int k = 0; k < live_keys; k++) begin
            mac_run[k] = mac_run[k] ^ gf_times(w.data_byte, pow_run[k]);
            pow_run[k] = gf_times(pow_run[k], key_reg[k]);
          end
          if (w.last_byte) begin
            ok = 1'b1;
            for (int k = 0; k < Slots; k++) begin
              v.mac[k] = (k < live_keys) ? mac_run[k] : 8'h00;
              if (k < live_keys && mac_run[k] != tag_acc[k]) begin
                ok = 1'b0;
              end
            end
            all_ok = all_ok & ok;
            v.chunk_match = ok;
            v.all_match = all_ok;
            verdicts_due.push_back(v);
            restart_chunk();
          end
        end
        default: ;
      endcase
    endfunction

    // Only the first hundred mismatches are printed; all are counted.
    task report(string what);
      mismatches++;
      if (mismatches <= 100) begin
        $display("mismatch: %s", what);
      end
    endtask

    task check_verdict(res_t got);
      res_t want;
      verdicts_seen++;
      if (verdicts_due.size() == 0) begin
        report($sformatf("verdict %0d arrived with nothing expected", verdicts_seen));
      end else begin
        want = verdicts_due.pop_front();
        for (int k = 0; k < Slots; k++) begin
          if (got.mac[k] !== want.mac[k]) begin
            report($sformatf("verdict %0d mac_%0d got %h want %h",
                             verdicts_seen, k, got.mac[k], want.mac[k]));
          end
        end
        if (got.chunk_match !== want.chunk_match) begin
          report($sformatf("verdict %0d chunk_match got %b want %b",
                           verdicts_seen, got.chunk_match, want.chunk_match));
        end
        if (got.all_match !== want.all_match) begin
          report($sformatf("verdict %0d all_match got %b want %b",
                           verdicts_seen, got.all_match, want.all_match));
        end
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic [7:0]  tag_byte_0_i = '0;
  logic [7:0]  tag_byte_1_i = '0;
  logic [7:0]  tag_byte_2_i = '0;
  logic [7:0]  coefficient_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  mac_0_o;
  logic [7:0]  mac_1_o;
  logic [7:0]  mac_2_o;
  logic        chunk_match_o;
  logic        all_match_o;

  pop_tracker  tracker;
  int unsigned words_used = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned quiet = 0;

  gf256_proof_of_possession_verifier #(
    .NumKeys(KeyCount)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .tag_byte_0_i (tag_byte_0_i),
    .tag_byte_1_i (tag_byte_1_i),
    .tag_byte_2_i (tag_byte_2_i),
    .coefficient_i(coefficient_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mac_0_o      (mac_0_o),
    .mac_1_o      (mac_1_o),
    .mac_2_o      (mac_2_o),
    .chunk_match_o(chunk_match_o),
    .all_match_o  (all_match_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result side: sample at the edge, then pick the ready level for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_verdict({mac_2_o, mac_1_o, mac_0_o, chunk_match_o, all_match_o});
    end
    out_ready_i <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Any accepted word, on either channel or the register port, counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("watchdog: nothing moved for %0d cycles, %0d verdicts outstanding",
               quiet, tracker.verdicts_due.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic item_t random_item();
    item_t w;
    w.cmd = 2'($urandom_range(3));
    w.data_byte = 8'($urandom());
    w.last_byte = 1'($urandom());
    w.tag_byte[0] = 8'($urandom());
    w.tag_byte[1] = 8'($urandom());
    w.tag_byte[2] = 8'($urandom());
    w.coefficient = 8'($urandom());
    return w;
  endfunction

  // Random word with a chosen command; the fields it does not use stay random.
  function automatic item_t shaped(logic [1:0] c);
    item_t w;
    w = random_item();
    w.cmd = c;
    return w;
  endfunction

  function automatic item_t word_of(logic [1:0] c, logic [7:0] data, logic last,
                                    logic [7:0] t0, logic [7:0] t1, logic [7:0] t2,
                                    logic [7:0] coef);
    item_t w;
    w.cmd = c;
    w.data_byte = data;
    w.last_byte = last;
    w.tag_byte[0] = t0;
    w.tag_byte[1] = t1;
    w.tag_byte[2] = t2;
    w.coefficient = coef;
    return w;
  endfunction

  // Valid is only lowered when an idle gap is taken, so it never drops and
  // rises within one time step.
  task automatic send_word(input item_t w);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid_i <= 1'b1;
    cmd_i <= w.cmd;
    data_byte_i <= w.data_byte;
    last_byte_i <= w.last_byte;
    tag_byte_0_i <= w.tag_byte[0];
    tag_byte_1_i <= w.tag_byte[1];
    tag_byte_2_i <= w.tag_byte[2];
    coefficient_i <= w.coefficient;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.absorb_word(w);
    if (w.cmd != CmdUnused) begin
      words_used++;
    end
  endtask

  // Setup cycle, then access cycle; the register takes the value at the
  // access edge. psel drops for a cycle so back-to-back writes stay clean.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom() & 32'hFFFF_FF00) | {24'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_key(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop sending, wait for every verdict, then give words that make no
  // verdict time to leave the pipeline.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.verdicts_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One chunk of data words. A matching chunk carries one tag row per byte
  // (key power as tag bytes, data byte as coefficient) plus a row that
  // cancels the tag sums left from earlier chunks. Tag rows are mixed in
  // among the data words, never after the last one.
  task automatic send_chunk(input int unsigned len, input bit want_match);
    item_t plan[$];
    item_t w;
    item_t row;
    byte_vec_t pw;
    int unsigned extra;
    pw = tracker.key_reg;
    for (int unsigned i = 0; i < len; i++) begin
      w = shaped(CmdData);
      w.last_byte = (i == len - 1);
      plan.push_back(w);
      if (want_match) begin
        row = shaped(CmdTag);
        row.coefficient = w.data_byte;
        for (int k = 0; k < Slots; k++) begin
          row.tag_byte[k] = pw[k];
          pw[k] = pop_tracker::gf_times(pw[k], tracker.key_reg[k]);
        end
        plan.insert($urandom_range(plan.size() - 1), row);
      end
    end
    if (want_match) begin
      row = shaped(CmdTag);
      row.coefficient = 8'h01;
      row.tag_byte = tracker.tag_acc;
      plan.insert($urandom_range(plan.size() - 1), row);
    end else begin
      extra = $urandom_range(2);
      repeat (extra) begin
        row = shaped(CmdTag);
        plan.insert($urandom_range(plan.size() - 1), row);
      end
    end
    foreach (plan[j]) begin
      send_word(plan[j]);
    end
  endtask

  // Mostly well-formed challenges; the rest is loose random words, which
  // include unused commands and chunks that start without a clear.
  task automatic run_traffic(input int unsigned upto);
    int unsigned chunks;
    int unsigned len;
    while (words_used < upto) begin
      if ($urandom_range(9) < 8) begin
        send_word(shaped(CmdClear));
        chunks = $urandom_range(1, 4);
        repeat (chunks) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 5);
          send_chunk(len, $urandom_range(9) < 7);
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_word(random_item());
      end
    end
  endtask

  initial begin
    tracker = new(KeyCount);
    src_idle_pct = 15;
    snk_idle_pct = 69;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset keys. Unused command and a last flag on
    // non-data words must be ignored; a zero coefficient adds nothing.
    send_word(word_of(CmdClear, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_word(word_of(CmdUnused, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(word_of(CmdTag, 8'hFF, 1'b1, 8'hFF, 8'h00, 8'h80, 8'hFF));
    send_word(word_of(CmdTag, 8'h00, 1'b0, 8'h01, 8'hFF, 8'h7F, 8'h80));
    send_word(word_of(CmdTag, 8'hAA, 1'b0, 8'h5A, 8'hC3, 8'h3C, 8'h00));
    send_word(word_of(CmdData, 8'h00, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(word_of(CmdData, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_word(word_of(CmdData, 8'h80, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00));
    // A matching chunk after a failed one leaves the sticky flag low until
    // the next clear.
    send_chunk(1, 1'b1);
    send_word(word_of(CmdClear, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_chunk(3, 1'b1);
    // Key changed in the middle of a chunk: the running power carries on and
    // only the next step uses the new key. The unused register is ignored.
    send_word(word_of(CmdData, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
    settle();
    write_reg(RegKey0, 8'h53);
    write_reg(RegUnused, 8'hA5);
    send_word(word_of(CmdData, 8'h55, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00));

    // Sender idles lightly, receiver heavily; keys at the extremes.
    settle();
    write_reg(RegKey0, 8'h00);
    write_reg(RegKey1, 8'hFF);
    write_reg(RegKey2, 8'h01);
    run_traffic(550);

    // Roles swapped, random keys.
    settle();
    src_idle_pct = 69;
    snk_idle_pct = 15;
    write_reg(RegKey0, 8'($urandom()));
    write_reg(RegKey1, 8'($urandom()));
    write_reg(RegKey2, 8'($urandom()));
    run_traffic(1100);

    // Full rate on both sides.
    settle();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_reg(RegKey0, 8'h80);
    write_reg(RegKey1, 8'h01);
    write_reg(RegKey2, 8'hFF);
    run_traffic(1650);

    settle();
    if (tracker.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
